// ===== hw/rtl/page_frame_bitmap_allocator_defines.svh =====
// Assertion macros for the page frame bitmap allocator.
// PFBA_ASSERT checks a property outside reset; PFBA_ASSERT_ALWAYS checks it at every edge.
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTH
`define PFBA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("page frame allocator check failed");
`define PFBA_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("page frame allocator check failed");
`else
`define PFBA_ASSERT(label, prop)
`define PFBA_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== hw/rtl/pfba_pkg.sv =====
`timescale 1ns / 1ps

package pfba_pkg;

    // Bitmap geometry.
    localparam int BITMAP_WORDS     = 32768;
    localparam int FRAME_BYTES_LOG2 = 12;
    localparam int WORD_BITS        = 32;
    localparam int BIT_W            = $clog2(WORD_BITS);
    localparam int WORD_AW          = $clog2(BITMAP_WORDS);
    localparam int SLOT_W           = WORD_AW + BIT_W;
    localparam int FRAME_W          = 32 - FRAME_BYTES_LOG2;

    localparam logic [FRAME_W:0]     TOTAL_FRAMES = (FRAME_W + 1)'(BITMAP_WORDS * WORD_BITS);
    localparam logic [WORD_AW-1:0]   LAST_WORD    = WORD_AW'(BITMAP_WORDS - 1);
    localparam logic [31:0]          FRAME_MASK   = 32'((1 << FRAME_BYTES_LOG2) - 1);
    localparam logic [WORD_BITS-1:0] WORD_ONES    = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] WORD_ONE     = WORD_BITS'(1);
    localparam logic [BIT_W-1:0]     TOP_BIT      = BIT_W'(WORD_BITS - 1);

    // Action codes.
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEM_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] frame_byte_addr;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result_addr;
        logic        success;
        logic [31:0] alloc_total;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic take;
        logic free_rd;
        logic free_wr;
        logic clr;
        logic res_ok;
        logic res_fail;
        logic out_load;
    } pfba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic win_empty;
        logic free_in_range;
        logic scan_hit;
        logic scan_end;
        logic clr_last;
    } pfba_stat_t;

endpackage

// ===== hw/rtl/page_frame_bitmap_allocator.sv =====
`timescale 1ns / 1ps

// First-fit page frame allocator over a bitmap of 32768 words, one bit per 4 KiB frame.
// After reset the block sweeps the bitmap to zero, one word per cycle, and stalls its input
// until the sweep ends; configuration writes are taken meanwhile. An allocate item reads
// one bitmap word per cycle from the first word of the window until it finds a free frame
// or reaches the window's last word. A free item goes through accept, read, write back
// and result, and a clear item sweeps the whole bitmap again. The single read and single
// write port of the bitmap memory set this pacing. One item is in work at a time; a
// finished result waits in an output register.
`include "page_frame_bitmap_allocator_defines.svh"

module page_frame_bitmap_allocator
    import pfba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata
);

    pfba_cmd_t  cmd;
    pfba_stat_t stat;

    // Sequencer for scan, free and clear.
    pfba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (in_data.action),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // Bitmap memory, window bounds, counter and result registers.
    pfba_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // Only one source writes the bitmap in any cycle.
    `PFBA_ASSERT_ALWAYS(a_one_writer, $onehot0({cmd.take, cmd.free_wr, cmd.clr}))

    // An accepted item keeps the block busy in the following cycle.
    `PFBA_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall)

    // A result is never loaded over one that has not been taken.
    `PFBA_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid || !out_stall))

endmodule

// ===== hw/rtl/pfba_datapath.sv =====
`timescale 1ns / 1ps

module pfba_datapath
    import pfba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             in_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_wdata,
    input  pfba_cmd_t            cmd,
    output pfba_stat_t           stat,
    output out_item_t            out_data
);

    // Bitmap storage and its registered read port.
    logic [WORD_BITS-1:0] bitmap_mem [BITMAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    // Control and configuration state.
    logic [31:0]        mem_low_reg;
    logic [31:0]        mem_high_reg;
    logic [31:0]        alloc_cnt_reg;
    logic               chk_vld_reg;
    logic [WORD_AW-1:0] clr_w_reg;

    // Payload registers.
    logic [WORD_AW-1:0] first_w_reg;
    logic [BIT_W-1:0]   first_b_reg;
    logic [WORD_AW-1:0] last_w_reg;
    logic [BIT_W-1:0]   last_b_reg;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic [WORD_AW-1:0] issue_w_reg;
    logic [WORD_AW-1:0] chk_w_reg;
    logic [31:0]        res_addr_reg;
    logic               res_ok_reg;
    out_item_t          out_data_reg;

    logic [32:0]          first_sum;
    logic [FRAME_W:0]     first_frame;
    logic [FRAME_W:0]     end_raw;
    logic [FRAME_W:0]     end_frame;
    logic [FRAME_W:0]     last_frame;
    logic [FRAME_W-1:0]   in_frame;
    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] avail;
    logic [BIT_W-1:0]     hit_b;
    logic                 mem_we;
    logic                 mem_re;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_AW-1:0]   rd_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Usable window in frames: low bound rounded up, high bound rounded down and cut to
    // the frames the bitmap covers.
    assign first_sum   = {1'b0, mem_low_reg} + {1'b0, FRAME_MASK};
    assign first_frame = first_sum[32:FRAME_BYTES_LOG2];
    assign end_raw     = {1'b0, mem_high_reg[31:FRAME_BYTES_LOG2]};
    assign end_frame   = (end_raw > TOTAL_FRAMES) ? TOTAL_FRAMES : end_raw;
    assign last_frame  = end_frame - (FRAME_W + 1)'(1);
    assign in_frame    = in_data.frame_byte_addr[31:FRAME_BYTES_LOG2];

    // Free bits of the word under check that fall inside the window.
    assign lo_mask = (chk_w_reg == first_w_reg) ? (WORD_ONES << first_b_reg) : WORD_ONES;
    assign hi_mask = (chk_w_reg == last_w_reg) ? (WORD_ONES >> (TOP_BIT - last_b_reg))
                                               : WORD_ONES;
    assign avail   = ~rd_data_reg & lo_mask & hi_mask;

    // Lowest free bit of the word under check.
    always_comb
    begin
        hit_b = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                hit_b = BIT_W'(i);
            end
        end
    end

    // Status toward the controller.
    always_comb
    begin
        stat.win_empty     = (first_frame >= end_frame);
        stat.free_in_range = ({1'b0, in_frame} < TOTAL_FRAMES);
        stat.scan_hit      = chk_vld_reg && (avail != '0);
        stat.scan_end      = chk_vld_reg && (chk_w_reg == last_w_reg);
        stat.clr_last      = (clr_w_reg == LAST_WORD);
    end

    // Memory port selection: one read and one write per cycle.
    assign mem_re  = cmd.scan | cmd.free_rd;
    assign rd_addr = cmd.scan ? issue_w_reg : free_slot_reg[SLOT_W-1:BIT_W];
    assign mem_we  = cmd.take | cmd.free_wr | cmd.clr;

    always_comb
    begin
        priority if (cmd.take)
        begin
            wr_addr = chk_w_reg;
            wr_data = rd_data_reg | (WORD_ONE << hit_b);
        end
        else if (cmd.free_wr)
        begin
            wr_addr = free_slot_reg[SLOT_W-1:BIT_W];
            wr_data = rd_data_reg & ~(WORD_ONE << free_slot_reg[BIT_W-1:0]);
        end
        else
        begin
            wr_addr = clr_w_reg;
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    // Configuration, allocation count and scan control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_low_reg   <= '0;
            mem_high_reg  <= '0;
            alloc_cnt_reg <= '0;
            chk_vld_reg   <= 1'b0;
            clr_w_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_MEM_LOW:  mem_low_reg  <= cfg_wdata;
                    CFG_MEM_HIGH: mem_high_reg <= cfg_wdata;
                    default:      mem_low_reg  <= mem_low_reg;
                endcase
            end
            if (cmd.take)
            begin
                alloc_cnt_reg <= alloc_cnt_reg + 32'd1;
            end
            if (cmd.load)
            begin
                chk_vld_reg <= 1'b0;
                clr_w_reg   <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    chk_vld_reg <= 1'b1;
                end
                if (cmd.clr)
                begin
                    clr_w_reg <= clr_w_reg + WORD_AW'(1);
                end
            end
        end
    end

    // Item, window, scan address and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_w_reg   <= first_frame[SLOT_W-1:BIT_W];
            first_b_reg   <= first_frame[BIT_W-1:0];
            last_w_reg    <= last_frame[SLOT_W-1:BIT_W];
            last_b_reg    <= last_frame[BIT_W-1:0];
            issue_w_reg   <= first_frame[SLOT_W-1:BIT_W];
            free_slot_reg <= in_frame[SLOT_W-1:0];
        end
        else if (cmd.scan)
        begin
            issue_w_reg <= issue_w_reg + WORD_AW'(1);
            chk_w_reg   <= issue_w_reg;
        end

        if (cmd.take)
        begin
            res_addr_reg <= 32'({chk_w_reg, hit_b}) << FRAME_BYTES_LOG2;
            res_ok_reg   <= 1'b1;
        end
        else if (cmd.res_ok)
        begin
            res_addr_reg <= '0;
            res_ok_reg   <= 1'b1;
        end
        else if (cmd.res_fail)
        begin
            res_addr_reg <= '0;
            res_ok_reg   <= 1'b0;
        end

        if (cmd.out_load)
        begin
            out_data_reg.result_addr <= res_addr_reg;
            out_data_reg.success     <= res_ok_reg;
            out_data_reg.alloc_total <= alloc_cnt_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule

// ===== hw/rtl/pfba_ctrl.sv =====
`timescale 1ns / 1ps

module pfba_ctrl
    import pfba_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_action,
    input  logic       out_stall,
    input  pfba_stat_t stat,
    output pfba_cmd_t  cmd,
    output logic       in_stall,
    output logic       out_valid
);

    typedef enum logic [6:0] {
        ST_CLR_INIT = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_ALLOC    = 7'b0000100,
        ST_FREE_RD  = 7'b0001000,
        ST_FREE_WR  = 7'b0010000,
        ST_CLR_ACT  = 7'b0100000,
        ST_RESP     = 7'b1000000
    } pfba_state_t;

    pfba_state_t state_reg;
    pfba_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR_INIT:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    unique case (in_action)
                        ACT_ALLOC:
                        begin
                            if (stat.win_empty)
                            begin
                                cmd.res_fail = 1'b1;
                                state_next   = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_ALLOC;
                            end
                        end
                        ACT_FREE:
                        begin
                            if (stat.free_in_range)
                            begin
                                state_next = ST_FREE_RD;
                            end
                            else
                            begin
                                cmd.res_fail = 1'b1;
                                state_next   = ST_RESP;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            state_next = ST_CLR_ACT;
                        end
                        default:
                        begin
                            cmd.res_fail = 1'b1;
                            state_next   = ST_RESP;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                // One word is read each cycle; the word checked is the one read in the previous cycle.
                priority if (stat.scan_hit)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RESP;
                end
                else if (stat.scan_end)
                begin
                    cmd.res_fail = 1'b1;
                    state_next   = ST_RESP;
                end
                else
                begin
                    cmd.scan = 1'b1;
                end
            end
            ST_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = ST_FREE_WR;
            end
            ST_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                cmd.res_ok  = 1'b1;
                state_next  = ST_RESP;
            end
            ST_CLR_ACT:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.res_ok = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLR_INIT;
            end
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pfba_pkg::*;

    // The fourth action code has no meaning in the block; it must be refused.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam longint unsigned FRAME_COUNT = BITMAP_WORDS * WORD_BITS;
    localparam int unsigned TOP_FRAME = (1 << FRAME_W) - 1;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_CLEARS = 4;
    localparam int PHASE_ITEMS = 170;
    localparam int ITEMS_PER_WINDOW = 40;

    typedef enum logic {ROW_ITEM, ROW_WINDOW} row_kind_t;

    // One row of the directed run: an item, or a new allocation window.
    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  action;
        logic [31:0] addr_or_low;
        logic [31:0] high;
        logic        fixed;
        out_item_t   want;
    } dir_row_t;

    localparam int N_STEPS = 23;
    localparam dir_row_t STEPS [N_STEPS] = '{
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 32'd0}},
        '{ROW_ITEM,   ACT_UNUSED, 32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b0, 32'd0}},
        '{ROW_ITEM,   ACT_FREE,   32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 32'd0}},
        '{ROW_WINDOW, ACT_ALLOC,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'hFFFF_FFFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 32'd1}},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b1, '{32'h0000_1000, 1'b1, 32'd2}},
        '{ROW_ITEM,   ACT_FREE,   32'h0000_0FFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 32'd2}},
        '{ROW_ITEM,   ACT_FREE,   32'h0000_0FFF, 32'h0, 1'b1, '{32'h0000_0000, 1'b1, 32'd2}},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_WINDOW, ACT_ALLOC,  32'h0001_F001, 32'h0002_3FFF, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h5A5A_5A5A, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'hA5A5_A5A5, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_CLEAR,  32'hFFFF_FFFF, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_WINDOW, ACT_ALLOC,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_WINDOW, ACT_ALLOC,  32'hFFFF_D001, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_FREE,   32'hFFFF_E5A5, 32'h0, 1'b0, '0},
        '{ROW_ITEM,   ACT_ALLOC,  32'h0000_0000, 32'h0, 1'b0, '0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_MEM_LOW;
    logic [31:0]          cfg_wdata = '0;

    // A typed-in expectation travels beside the item it belongs to.
    logic      fixed_flag = 1'b0;
    out_item_t fixed_want = '0;

    // Shadow of the allocator: frame bitmap, allocation count and window bounds.
    bit [31:0] frame_map [BITMAP_WORDS];
    bit [31:0] alloc_count;
    bit [31:0] bound_low;
    bit [31:0] bound_high;

    out_item_t pending_results [$];
    int error_count = 0;
    int sent_count = 0;
    int seen_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int clears_left = RANDOM_CLEARS;

    // Window of the current setting in frames, used to aim frees at live frames.
    int unsigned win_first = 0;
    int unsigned win_end = 0;

    page_frame_bitmap_allocator uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic void wipe_frames();
        foreach (frame_map[w])
        begin
            frame_map[w] = '0;
        end
    endfunction

    // First fit: lowest free frame between the rounded bounds, skipping full words.
    function automatic bit take_lowest_frame(output logic [31:0] frame);
        longint unsigned first_f;
        longint unsigned end_f;
        longint unsigned w;
        longint unsigned f;
        int              b;
        logic [31:0]     word;
        frame = '0;
        first_f = ({32'd0, bound_low} + FRAME_MASK) >> FRAME_BYTES_LOG2;
        end_f = {32'd0, bound_high} >> FRAME_BYTES_LOG2;
        if (end_f > FRAME_COUNT)
            end_f = FRAME_COUNT;
        if (first_f >= end_f)
            return 1'b0;
        for (w = first_f / WORD_BITS; w * WORD_BITS < end_f; w++)
        begin
            word = frame_map[w];
            if (word == WORD_ONES)
                continue;
            for (b = 0; b < WORD_BITS; b++)
            begin
                f = w * WORD_BITS + b;
                if (f < first_f)
                    continue;
                if (f >= end_f)
                    return 1'b0;
                if (!word[b])
                begin
                    frame_map[w][b] = 1'b1;
                    frame = 32'(f);
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Expected result of one item; updates the shadow state as the block would.
    function automatic out_item_t predict_step(in_item_t it);
        out_item_t   res;
        logic [31:0] frame;
        res = '0;
        case (it.action)
            ACT_ALLOC:
            begin
                if (take_lowest_frame(frame))
                begin
                    alloc_count++;
                    res.result_addr = frame << FRAME_BYTES_LOG2;
                    res.success = 1'b1;
                end
            end
            ACT_FREE:
            begin
                frame = it.frame_byte_addr >> FRAME_BYTES_LOG2;
                if (frame < FRAME_COUNT)
                begin
                    frame_map[frame / WORD_BITS][frame % WORD_BITS] = 1'b0;
                    res.success = 1'b1;
                end
            end
            ACT_CLEAR:
            begin
                wipe_frames();
                res.success = 1'b1;
            end
            default: ;
        endcase
        res.alloc_total = alloc_count;
        return res;
    endfunction

    task automatic compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
        end
    endtask

    // Track register writes and accepted items, and check each result in order.
    always @(posedge clk)
    begin : watch_ports
        out_item_t want;
        if (!rst_n)
        begin
            wipe_frames();
            alloc_count = '0;
            bound_low = '0;
            bound_high = '0;
        end
        else
        begin
            if (cfg_we && cfg_idx == CFG_MEM_LOW)
                bound_low = cfg_wdata;
            if (cfg_we && cfg_idx == CFG_MEM_HIGH)
                bound_high = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                want = predict_step(in_data);
                pending_results.push_back(fixed_flag ? fixed_want : want);
            end
            if (out_valid && !out_stall)
            begin
                seen_count <= seen_count + 1;
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected item, expected none, actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("result_addr", want.result_addr, out_data.result_addr);
                    compare_field("success", 32'(want.success), 32'(out_data.success));
                    compare_field("alloc_total", want.alloc_total, out_data.alloc_total);
                end
            end
        end
    end

    // Result side: random stalls, or one long hold-off when the stimulus asks for it.
    always @(posedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            out_stall   <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic send_item(in_item_t it, logic fixed, out_item_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_data    <= it;
        fixed_flag <= fixed;
        fixed_want <= want;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (seen_count != sent_count)
            @(posedge clk);
    endtask

    // Both bounds are written back to back once the block has gone idle.
    task automatic write_window(logic [31:0] low, logic [31:0] high);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_MEM_LOW;
        cfg_wdata <= low;
        @(posedge clk);
        cfg_idx   <= CFG_MEM_HIGH;
        cfg_wdata <= high;
        @(posedge clk);
        cfg_we    <= 1'b0;
        win_first = 32'(({1'b0, low} + {1'b0, FRAME_MASK}) >> FRAME_BYTES_LOG2);
        win_end = high >> FRAME_BYTES_LOG2;
    endtask

    // Mostly small windows low in memory, so frames run out and get reused.
    task automatic new_window();
        int unsigned mode;
        int unsigned base;
        int unsigned span;
        logic [31:0] low;
        logic [31:0] high;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 300);
        span = $urandom_range(1, 80);
        low = '0;
        high = '1;
        case (mode)
            0: ;
            1:
            begin
                low = $urandom();
                high = $urandom();
            end
            2:
            begin
                low = $urandom();
                high = low - $urandom_range(0, 1 << 14);
            end
            3: base = TOP_FRAME - span;
            default: ;
        endcase
        if (mode >= 3)
        begin
            low = (base << FRAME_BYTES_LOG2) - ((base != 0) ? $urandom_range(0, FRAME_MASK) : 0);
            high = ((base + span) << FRAME_BYTES_LOG2) | $urandom_range(0, FRAME_MASK);
        end
        write_window(low, high);
    endtask

    // Allocations and frees aimed at the window dominate; clears stay rare.
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned lo_f;
        int unsigned hi_f;
        it.action = ACT_ALLOC;
        it.frame_byte_addr = $urandom();
        pick = $urandom_range(0, 199);
        if (pick < 2 && clears_left > 0)
        begin
            it.action = ACT_CLEAR;
            clears_left--;
        end
        else if (pick < 10)
        begin
            it.action = ACT_UNUSED;
        end
        else if (pick >= 110)
        begin
            it.action = ACT_FREE;
            if (win_first < win_end && $urandom_range(0, 4) != 0)
            begin
                lo_f = (win_first > 2) ? win_first - 2 : 0;
                hi_f = (win_end < TOP_FRAME) ? win_end + 1 : TOP_FRAME;
                it.frame_byte_addr = {FRAME_W'($urandom_range(lo_f, hi_f)),
                                      FRAME_BYTES_LOG2'($urandom())};
            end
        end
        return it;
    endfunction

    initial
    begin : stimulus
        in_item_t it;
        int       p;
        int       i;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows first.
        foreach (STEPS[s])
        begin
            if (STEPS[s].kind == ROW_WINDOW)
            begin
                write_window(STEPS[s].addr_or_low, STEPS[s].high);
            end
            else
            begin
                it.action = STEPS[s].action;
                it.frame_byte_addr = STEPS[s].addr_or_low;
                send_item(it, STEPS[s].fixed, STEPS[s].want);
            end
        end

        // Random phases with different idling on each side.
        for (p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % ITEMS_PER_WINDOW == 0)
                    new_window();
                // Hold the result side off while items keep coming, to back the block up.
                if (p == 2 && i == 1)
                    hold_requests <= hold_requests + 1;
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            if (pending_results.size() != 0)
                $display("%0t: %0d expected items never arrived", $time,
                         pending_results.size());
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
